@@ hw/rtl/ial_pkg.sv @@
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants for the indexed array list: command and
// result words, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 4;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_FIND   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOB      = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               kind;
        logic [3:0]               index;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [2:0]               found_index;
        logic [1:0]               status;
        logic [3:0]               entry_count;
    } t_result;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    // broadcast to every cell in the row
    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         index;
        logic signed [VAL_W-1:0]  value;
        logic [CNT_W-1:0]         count;
    } t_cell_ctl;

endpackage

@@ hw/rtl/indexed_array_list.sv @@
// ----------------------------------------------------------------------------
// indexed_array_list
// Bounded ordered list of signed 32-bit words kept in a row of cells:
// read, insert and remove by logical index, find by value, one result per command.
// ----------------------------------------------------------------------------
// channel   | direction | handshake                  | payload
// command   | in        | start high, busy low       | i_cmd    (ial_pkg::t_cmd)
// result    | out       | o_done high for one cycle  | o_result (ial_pkg::t_result)
//
// the cell row applies each command; its result is registered and appears on the
// cycle after acceptance, and a new command may be given every cycle.
// busy stays low: the cells shift, compare and select in parallel.
// i_rst_n (synchronous, active low) empties the list and clears o_done.
// the receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module indexed_array_list (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ial_pkg::t_cmd     i_cmd,
    output logic              o_done,
    output ial_pkg::t_result  o_result
);

    localparam int N = ial_pkg::CAPACITY;

    logic [ial_pkg::CNT_W-1:0]          r_count;
    logic [ial_pkg::CNT_W-1:0]          n_count;
    logic                               r_done;
    ial_pkg::t_result                   r_result;
    ial_pkg::t_result                   n_result;
    ial_pkg::t_cell_ctl                 w_ctl;
    logic                               w_accept;

    logic signed [ial_pkg::VAL_W-1:0]   w_entry   [N];
    logic                               w_hit     [N+1];
    logic [ial_pkg::IDX_W-1:0]          w_hit_idx [N+1];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_hit[0]     = 1'b0;
    assign w_hit_idx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic signed [ial_pkg::VAL_W-1:0] w_left;
            logic signed [ial_pkg::VAL_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = i_cmd.value;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end
            if (g == N-1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_mid_r
                assign w_right = w_entry[g+1];
            end
            ial_cell u_cell (
                .i_clk     (i_clk),
                .i_pos     (ial_pkg::IDX_W'(g)),
                .i_ctl     (w_ctl),
                .i_left    (w_left),
                .i_right   (w_right),
                .i_hit     (w_hit[g]),
                .i_hit_idx (w_hit_idx[g]),
                .o_entry   (w_entry[g]),
                .o_hit     (w_hit[g+1]),
                .o_hit_idx (w_hit_idx[g+1])
            );
        end
    endgenerate

    always_comb begin
        w_ctl.op    = ial_pkg::CELL_HOLD;
        w_ctl.index = i_cmd.index[ial_pkg::IDX_W-1:0];
        w_ctl.value = i_cmd.value;
        w_ctl.count = r_count;
        n_count     = r_count;
        n_result.read_value  = '0;
        n_result.found_index = '0;
        n_result.status      = ial_pkg::ST_OK;
        case (ial_pkg::t_kind'(i_cmd.kind))
            ial_pkg::KIND_READ: begin
                if (i_cmd.index >= r_count) begin
                    n_result.read_value = '1;
                    n_result.status     = ial_pkg::ST_OOB;
                end else begin
                    n_result.read_value = w_entry[i_cmd.index[ial_pkg::IDX_W-1:0]];
                end
            end
            ial_pkg::KIND_INSERT: begin
                if (r_count == ial_pkg::CNT_W'(N)) begin
                    n_result.status = ial_pkg::ST_FULL;
                end else if (i_cmd.index > r_count) begin
                    n_result.status = ial_pkg::ST_OOB;
                end else begin
                    w_ctl.op = ial_pkg::CELL_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            ial_pkg::KIND_REMOVE: begin
                if (i_cmd.index >= r_count) begin
                    n_result.status = ial_pkg::ST_OOB;
                end else begin
                    w_ctl.op = ial_pkg::CELL_REMOVE;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                if (w_hit[N]) begin
                    n_result.found_index = 3'(w_hit_idx[N]);
                end else begin
                    n_result.status = ial_pkg::ST_NOTFOUND;
                end
            end
        endcase
        if (!w_accept) begin
            w_ctl.op = ial_pkg::CELL_HOLD;
            n_count  = r_count;
        end
        n_result.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ hw/rtl/ial_cell.sv @@
// ----------------------------------------------------------------------------
// ial_cell
// One list position: holds an entry, takes its left or right neighbor on
// insert or remove, and extends the first-match chain for find.
// ----------------------------------------------------------------------------
module ial_cell (
    input  logic                                i_clk,
    input  logic [ial_pkg::IDX_W-1:0]           i_pos,
    input  ial_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [ial_pkg::VAL_W-1:0]    i_left,
    input  logic signed [ial_pkg::VAL_W-1:0]    i_right,
    input  logic                                i_hit,
    input  logic [ial_pkg::IDX_W-1:0]           i_hit_idx,
    output logic signed [ial_pkg::VAL_W-1:0]    o_entry,
    output logic                                o_hit,
    output logic [ial_pkg::IDX_W-1:0]           o_hit_idx
);

    logic signed [ial_pkg::VAL_W-1:0] r_entry;
    logic signed [ial_pkg::VAL_W-1:0] n_entry;
    logic                             w_match;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            ial_pkg::CELL_INSERT: begin
                if (i_pos == i_ctl.index) begin
                    n_entry = i_ctl.value;
                end else if (i_pos > i_ctl.index) begin
                    n_entry = i_left;
                end
            end
            ial_pkg::CELL_REMOVE: begin
                if (i_pos >= i_ctl.index) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // only held entries take part in the search
    assign w_match   = ({1'b0, i_pos} < ial_pkg::CNT_W'(i_ctl.count)) &&
                       (r_entry == i_ctl.value);
    assign o_hit     = i_hit | w_match;
    assign o_hit_idx = i_hit ? i_hit_idx : i_pos;
    assign o_entry   = r_entry;

endmodule
